// ----- design/msd_pkg.sv -----
// shared types, constants and register codes for the media stream deframer
package msd_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 24;
  localparam int unsigned HEADER_BYTES    = 28;
  localparam int unsigned MESSAGE_BYTES   = 136;
  localparam int unsigned CFG_DATA_BITS   = 24;
  localparam int unsigned CFG_INDEX_BITS  = 3;

  localparam logic [7:0]  SYNC_FIRST_RST   = 8'd0;
  localparam logic [7:0]  SYNC_SECOND_RST  = 8'd0;
  localparam logic [7:0]  VIDEO_CODE_RST   = 8'd0;
  localparam logic [7:0]  AUDIO_CODE_RST   = 8'd1;
  localparam logic [7:0]  MESSAGE_CODE_RST = 8'd2;
  localparam logic [31:0] VIDEO_LIMIT_RST  = 32'd3584000;
  localparam logic [31:0] AUDIO_LIMIT_RST  = 32'd160;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SYNC_FIRST   = 3'd0,
    REG_SYNC_SECOND  = 3'd1,
    REG_VIDEO_CODE   = 3'd2,
    REG_AUDIO_CODE   = 3'd3,
    REG_MESSAGE_CODE = 3'd4,
    REG_VIDEO_LIMIT  = 3'd5,
    REG_AUDIO_LIMIT  = 3'd6
  } msd_reg_e;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SKIP    = 3'd1,
    PH_TYPE    = 3'd2,
    PH_HEADER  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_MESSAGE = 3'd5
  } msd_phase_e;

  typedef enum logic [1:0] {
    KIND_VIDEO   = 2'd0,
    KIND_AUDIO   = 2'd1,
    KIND_MESSAGE = 2'd2
  } msd_kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
  } msd_in_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        stream_kind;
    logic        has_byte;
    logic        frame_last;
    logic [63:0] frame_pts;
  } msd_out_t;

  typedef struct packed {
    logic [CFG_INDEX_BITS-1:0] reg_index;
    logic [CFG_DATA_BITS-1:0]  reg_value;
  } msd_cfg_t;

  // byte-wide codes seen by the parser
  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] video_code;
    logic [7:0] audio_code;
    logic [7:0] message_code;
  } msd_codes_t;

endpackage

// ----- design/msd_stream_if.sv -----
// valid/ready channel carrying one payload item per transfer
interface msd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/msd_parser.sv -----
// frame parser: phase machine, header capture and payload tagging
module msd_parser #(
  parameter int unsigned LENGTH_BITS = msd_pkg::LENGTH_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             byte_i,
  input  msd_pkg::msd_codes_t    codes_i,
  input  logic [LENGTH_BITS-1:0] video_limit_i,
  input  logic [LENGTH_BITS-1:0] audio_limit_i,
  output logic                   res_valid_o,
  output msd_pkg::msd_out_t      res_o
);

  msd_pkg::msd_phase_e    phase_q, phase_d;
  msd_pkg::msd_kind_e     kind_q, kind_d;
  logic [7:0]             prior_q, prior_d;
  logic                   prior_valid_q, prior_valid_d;
  logic [7:0]             hdr_cnt_q, hdr_cnt_d;
  logic [63:0]            pts_q, pts_d;
  logic [31:0]            len_q, len_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;

  logic        hdr_done;
  logic [31:0] len_full;
  logic        len_zero;
  logic        vid_over;
  logic        aud_over;
  logic        rem_last;
  logic        msg_done;
  logic        sync_hit;
  logic        hunting;

  assign hdr_done = (hdr_cnt_q == 8'(msd_pkg::HEADER_BYTES - 1));
  assign msg_done = (hdr_cnt_q >= 8'(msd_pkg::MESSAGE_BYTES - 1));
  // last header byte is the top byte of the little-endian length
  assign len_full = {byte_i, len_q[23:0]};
  assign len_zero = (len_full == 32'd0);
  assign vid_over = (len_full > 32'(video_limit_i));
  assign aud_over = (len_full > 32'(audio_limit_i));
  assign rem_last = (rem_q <= LENGTH_BITS'(1));
  assign sync_hit = prior_valid_q && (prior_q == codes_i.sync_first) &&
                    (byte_i == codes_i.sync_second);
  assign hunting  = !((phase_q == msd_pkg::PH_SKIP) || (phase_q == msd_pkg::PH_TYPE) ||
                      (phase_q == msd_pkg::PH_HEADER) || (phase_q == msd_pkg::PH_PAYLOAD) ||
                      (phase_q == msd_pkg::PH_MESSAGE));

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      msd_pkg::PH_SKIP: begin
        phase_d = msd_pkg::PH_TYPE;
      end
      msd_pkg::PH_TYPE: begin
        priority if (byte_i == codes_i.video_code) begin
          phase_d = msd_pkg::PH_HEADER;
        end else if (byte_i == codes_i.audio_code) begin
          phase_d = msd_pkg::PH_HEADER;
        end else if (byte_i == codes_i.message_code) begin
          phase_d = msd_pkg::PH_MESSAGE;
        end else begin
          phase_d = msd_pkg::PH_HUNT;
        end
      end
      msd_pkg::PH_HEADER: begin
        if (hdr_done) begin
          if (kind_q == msd_pkg::KIND_VIDEO) begin
            phase_d = (vid_over || len_zero) ? msd_pkg::PH_HUNT : msd_pkg::PH_PAYLOAD;
          end else begin
            phase_d = (aud_over || len_zero) ? msd_pkg::PH_HUNT : msd_pkg::PH_PAYLOAD;
          end
        end
      end
      msd_pkg::PH_PAYLOAD: begin
        if (rem_last) begin
          phase_d = msd_pkg::PH_HUNT;
        end
      end
      msd_pkg::PH_MESSAGE: begin
        if (msg_done) begin
          phase_d = msd_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_d = sync_hit ? msd_pkg::PH_SKIP : msd_pkg::PH_HUNT;
      end
    endcase
  end

  // datapath registers
  always_comb begin
    kind_d        = kind_q;
    prior_d       = prior_q;
    prior_valid_d = prior_valid_q;
    hdr_cnt_d     = hdr_cnt_q;
    pts_d         = pts_q;
    len_d         = len_q;
    rem_d         = rem_q;
    if (hunting) begin
      if (sync_hit) begin
        prior_d       = 8'd0;
        prior_valid_d = 1'b0;
      end else begin
        prior_d       = byte_i;
        prior_valid_d = 1'b1;
      end
    end else begin
      unique case (phase_q)
        msd_pkg::PH_TYPE: begin
          hdr_cnt_d = 8'd0;
          pts_d     = 64'd0;
          len_d     = 32'd0;
          priority if (byte_i == codes_i.video_code) begin
            kind_d = msd_pkg::KIND_VIDEO;
          end else if (byte_i == codes_i.audio_code) begin
            kind_d = msd_pkg::KIND_AUDIO;
          end else if (byte_i == codes_i.message_code) begin
            kind_d = msd_pkg::KIND_MESSAGE;
          end else begin
            kind_d = kind_q;
          end
        end
        msd_pkg::PH_HEADER: begin
          hdr_cnt_d = hdr_cnt_q + 8'd1;
          // bytes 16..19 high pts word, 20..23 low word, 24..27 length
          if (hdr_cnt_q[7:2] == 6'd4) begin
            pts_d[{1'b1, hdr_cnt_q[1:0], 3'b000} +: 8] = byte_i;
          end else if (hdr_cnt_q[7:2] == 6'd5) begin
            pts_d[{1'b0, hdr_cnt_q[1:0], 3'b000} +: 8] = byte_i;
          end else if (hdr_cnt_q[7:2] == 6'd6) begin
            len_d[{hdr_cnt_q[1:0], 3'b000} +: 8] = byte_i;
          end
          rem_d = len_full[LENGTH_BITS-1:0];
        end
        msd_pkg::PH_PAYLOAD: begin
          rem_d = rem_q - LENGTH_BITS'(1);
        end
        msd_pkg::PH_MESSAGE: begin
          hdr_cnt_d = hdr_cnt_q + 8'd1;
        end
        default: begin
          hdr_cnt_d = hdr_cnt_q;
        end
      endcase
      if (phase_d == msd_pkg::PH_HUNT) begin
        prior_d       = 8'd0;
        prior_valid_d = 1'b0;
        hdr_cnt_d     = 8'd0;
      end
    end
  end

  // result of this byte
  always_comb begin
    res_valid_o        = 1'b0;
    res_o.payload_byte = 8'd0;
    res_o.stream_kind  = (kind_q == msd_pkg::KIND_AUDIO);
    res_o.has_byte     = 1'b0;
    res_o.frame_last   = 1'b1;
    res_o.frame_pts    = pts_q;
    if (phase_q == msd_pkg::PH_PAYLOAD) begin
      res_valid_o        = 1'b1;
      res_o.payload_byte = byte_i;
      res_o.has_byte     = 1'b1;
      res_o.frame_last   = rem_last;
    end else if ((phase_q == msd_pkg::PH_HEADER) && hdr_done &&
                 (kind_q == msd_pkg::KIND_VIDEO) && !vid_over && len_zero) begin
      // empty video frame marker
      res_valid_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= msd_pkg::PH_HUNT;
      kind_q        <= msd_pkg::KIND_VIDEO;
      prior_q       <= 8'd0;
      prior_valid_q <= 1'b0;
      hdr_cnt_q     <= 8'd0;
      pts_q         <= 64'd0;
      len_q         <= 32'd0;
      rem_q         <= '0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      kind_q        <= kind_d;
      prior_q       <= prior_d;
      prior_valid_q <= prior_valid_d;
      hdr_cnt_q     <= hdr_cnt_d;
      pts_q         <= pts_d;
      len_q         <= len_d;
      rem_q         <= rem_d;
    end
  end

endmodule

// ----- design/media_stream_deframer.sv -----
// top level of the media stream deframer: config registers, byte register, result register
//
//   channel | dir | payload                                              | transfer
//   rx_i    | in  | rx_byte                                              | valid & ready
//   res_o   | out | payload_byte, stream_kind, has_byte, frame_last, pts | valid & ready
//   cfg_i   | in  | reg_index, reg_value                                 | valid & ready
//
// one byte per cycle sustained while the result register is not stalled; a transferred byte
// waits in the input register until it is parsed, and any result of that byte loads the output
// register when it is parsed; res_o.valid is driven by that output register.
// reset clears all parse state and loads the register defaults; no clearing pass.
// a stalled result register holds the parser, and the input register then holds one byte
// before rx_i.ready drops. cfg_i is always ready.
module media_stream_deframer #(
  parameter int unsigned LENGTH_BITS = msd_pkg::LENGTH_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  msd_stream_if.sink   rx_i,
  msd_stream_if.source res_o,
  msd_stream_if.sink   cfg_i
);

  msd_pkg::msd_codes_t    codes_q;
  logic [LENGTH_BITS-1:0] vid_lim_q;
  logic [LENGTH_BITS-1:0] aud_lim_q;

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q;
  msd_pkg::msd_out_t out_q;

  logic              step;
  logic              res_valid;
  msd_pkg::msd_out_t res;
  msd_pkg::msd_cfg_t cfg;
  msd_pkg::msd_in_t  rx;

  assign cfg = cfg_i.data;
  assign rx  = rx_i.data;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.sync_first   <= msd_pkg::SYNC_FIRST_RST;
      codes_q.sync_second  <= msd_pkg::SYNC_SECOND_RST;
      codes_q.video_code   <= msd_pkg::VIDEO_CODE_RST;
      codes_q.audio_code   <= msd_pkg::AUDIO_CODE_RST;
      codes_q.message_code <= msd_pkg::MESSAGE_CODE_RST;
      vid_lim_q            <= LENGTH_BITS'(msd_pkg::VIDEO_LIMIT_RST);
      aud_lim_q            <= LENGTH_BITS'(msd_pkg::AUDIO_LIMIT_RST);
    end else if (cfg_i.valid) begin
      unique case (cfg.reg_index)
        msd_pkg::REG_SYNC_FIRST:   codes_q.sync_first   <= cfg.reg_value[7:0];
        msd_pkg::REG_SYNC_SECOND:  codes_q.sync_second  <= cfg.reg_value[7:0];
        msd_pkg::REG_VIDEO_CODE:   codes_q.video_code   <= cfg.reg_value[7:0];
        msd_pkg::REG_AUDIO_CODE:   codes_q.audio_code   <= cfg.reg_value[7:0];
        msd_pkg::REG_MESSAGE_CODE: codes_q.message_code <= cfg.reg_value[7:0];
        msd_pkg::REG_VIDEO_LIMIT:  vid_lim_q <= LENGTH_BITS'(cfg.reg_value);
        msd_pkg::REG_AUDIO_LIMIT:  aud_lim_q <= LENGTH_BITS'(cfg.reg_value);
        default: ;
      endcase
    end
  end

  // parse the held byte when the result register has room
  assign step       = in_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx.rx_byte;
    end
  end

  msd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .byte_i        (in_byte_q),
    .codes_i       (codes_q),
    .video_limit_i (vid_lim_q),
    .audio_limit_i (aud_lim_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

endmodule
